// ===== design/ivwm_pkg.sv =====
package ivwm_pkg;

    localparam int VALUE_W = 32;
    localparam int ERROR_W = 32;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = ERROR_W + SCALE_W;   // error * error_scale
    localparam int SCALE_FRAC = 14;               // Q2.14 fraction bits
    localparam int ES_W    = PROD_W - SCALE_FRAC; // scaled error, 34 bits
    localparam int ESQ_W   = 21;                  // es bits once es <= 2^20
    localparam int WEIGHT_W = 32;
    localparam int WSUM_W  = 48;
    localparam int VWSUM_W = 64;
    localparam int DVD_W   = 64;                  // divider dividend/quotient shifter
    localparam int CNT_W   = 7;
    localparam int RECIP_W = 41;                  // 2^40 / d fits 41 bits
    localparam int ROOT_W  = 42;

    localparam logic [ES_W-1:0]      ES_LIMIT  = ES_W'(64'd1 << 20);
    localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX = '1;
    localparam logic [WSUM_W-1:0]    WSUM_MAX  = '1;
    localparam logic [CNT_W-1:0]     RECIP_STEPS = CNT_W'(RECIP_W);
    localparam logic [CNT_W-1:0]     MEAN_STEPS  = CNT_W'(DVD_W);
    localparam logic [CNT_W-1:0]     ROOT_STEPS  = CNT_W'(21);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_ESMUL  = 12'b0000_0000_0010,
        ST_SQMUL  = 12'b0000_0000_0100,
        ST_WDIV   = 12'b0000_0000_1000,
        ST_WCLAMP = 12'b0000_0001_0000,
        ST_VWMUL  = 12'b0000_0010_0000,
        ST_ACC    = 12'b0000_0100_0000,
        ST_FIN    = 12'b0000_1000_0000,
        ST_MDIV   = 12'b0001_0000_0000,
        ST_EDIV   = 12'b0010_0000_0000,
        ST_ROOT   = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== design/inverse_variance_weighted_mean.sv =====
// Channel | Direction | tdata (low bit up)                      | tuser / tlast
// s_      | in        | value[31:0] error[63:32] scale[79:64]   | tlast = last of bin
// m_      | out       | mean[31:0] mean_error[63:32]            | tuser = no_weight, saturated
//
// One item at a time: es and es^2 multiplies, 41 steps of a one-bit-per-cycle restoring
// divider for 2^40/es^2, clamp, value*weight, accumulate (zero weight skips divide and clamp).
// The last item of a bin adds setup, 64 divider steps for the mean, 41 for 2^40/sum_w on
// the same shared divider, 21 root steps on the root registers, and the output write.
// aresetn (sync, active low) clears the sums, the FSM and m_tvalid.
// s_tready is high only in idle; the output write waits only while the output register
// still holds an item that m_tready has not taken.
module inverse_variance_weighted_mean (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // value[31:0], error[63:32], error_scale[79:64]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // mean[31:0], mean_error[63:32]
    output logic [1:0]  m_tuser     // no_weight[0], saturated[1]
);

    ivwm_pkg::state_t state_reg, state_next;

    // latched item
    logic [ivwm_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [ivwm_pkg::ERROR_W-1:0] err_reg, err_next;
    logic [ivwm_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                         last_reg, last_next;

    // weight path
    logic [ivwm_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [ivwm_pkg::WEIGHT_W-1:0] w_reg, w_next;
    logic signed [63:0]            vw_reg, vw_next;

    // bin state
    logic [ivwm_pkg::WSUM_W-1:0]  ws_reg, ws_next;
    logic signed [63:0]           wvs_reg, wvs_next;
    logic                         ovf_reg, ovf_next;

    // shared bit-serial divider
    logic [ivwm_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [ivwm_pkg::WSUM_W-1:0] rem_reg, rem_next;
    logic [ivwm_pkg::WSUM_W-1:0] dsr_reg, dsr_next;
    logic [ivwm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    // bit-serial square root
    logic [ivwm_pkg::RECIP_W-1:0] x_reg, x_next;
    logic [ivwm_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [ivwm_pkg::RECIP_W-1:0] bit_reg, bit_next;

    // result staging and output register
    logic [31:0] mean_reg, mean_next;
    logic        sat_reg, sat_next;
    logic        nw_reg, nw_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // datapath terms
    logic [ivwm_pkg::ES_W-1:0]  es;
    logic [ivwm_pkg::ESQ_W-1:0] es_lo;
    logic [2*ivwm_pkg::ESQ_W-1:0] es_sq;
    logic [ivwm_pkg::WSUM_W:0]  div_shift;
    logic [ivwm_pkg::WSUM_W+1:0] div_diff;
    logic                        div_qbit;
    logic [ivwm_pkg::DVD_W-1:0]  div_dvd;
    logic [ivwm_pkg::WSUM_W-1:0] div_rem;
    logic signed [64:0]          vw_prod;
    logic [ivwm_pkg::WSUM_W:0]   ws_sum;
    logic signed [64:0]          wvs_sum;
    logic [63:0]                 wvs_mag;
    logic [ivwm_pkg::ROOT_W-1:0] root_trial;
    logic                        root_take;
    logic                        out_free;

    assign s_tready = (state_reg == ivwm_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign es    = prod_reg[ivwm_pkg::PROD_W-1:ivwm_pkg::SCALE_FRAC];
    assign es_lo = es[ivwm_pkg::ESQ_W-1:0];
    assign es_sq = es_lo * es_lo;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign div_shift = {rem_reg, dvd_reg[ivwm_pkg::DVD_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, dsr_reg};
    assign div_qbit  = !div_diff[ivwm_pkg::WSUM_W+1];
    assign div_rem   = div_qbit ? div_diff[ivwm_pkg::WSUM_W-1:0]
                                : div_shift[ivwm_pkg::WSUM_W-1:0];
    assign div_dvd   = {dvd_reg[ivwm_pkg::DVD_W-2:0], div_qbit};

    assign vw_prod = $signed(value_reg) * $signed({1'b0, w_reg});
    assign ws_sum  = {1'b0, ws_reg} + (ivwm_pkg::WSUM_W+1)'(w_reg);
    assign wvs_sum = {wvs_reg[63], wvs_reg} + {vw_reg[63], vw_reg};
    assign wvs_mag = wvs_reg[63] ? 64'(-wvs_reg) : 64'(wvs_reg);

    assign root_trial = root_reg + ivwm_pkg::ROOT_W'(bit_reg);
    assign root_take  = ivwm_pkg::ROOT_W'(x_reg) >= root_trial;

    always_comb begin
        state_next    = state_reg;
        value_next    = value_reg;
        err_next      = err_reg;
        scale_next    = scale_reg;
        last_next     = last_reg;
        prod_next     = prod_reg;
        w_next        = w_reg;
        vw_next       = vw_reg;
        ws_next       = ws_reg;
        wvs_next      = wvs_reg;
        ovf_next      = ovf_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        mean_next     = mean_reg;
        sat_next      = sat_reg;
        nw_next       = nw_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ivwm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = s_tdata[31:0];
                    err_next   = s_tdata[63:32];
                    scale_next = s_tdata[79:64];
                    last_next  = s_tlast;
                    state_next = ivwm_pkg::ST_ESMUL;
                end
            end
            ivwm_pkg::ST_ESMUL: begin
                prod_next  = err_reg * scale_reg;
                state_next = ivwm_pkg::ST_SQMUL;
            end
            ivwm_pkg::ST_SQMUL: begin
                // es of zero or above 2^20 gives zero weight
                if (es == '0 || es > ivwm_pkg::ES_LIMIT) begin
                    w_next     = '0;
                    state_next = ivwm_pkg::ST_VWMUL;
                end else begin
                    dsr_next   = ivwm_pkg::WSUM_W'(es_sq);
                    dvd_next   = {1'b1, {(ivwm_pkg::DVD_W-1){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = ivwm_pkg::RECIP_STEPS;
                    state_next = ivwm_pkg::ST_WDIV;
                end
            end
            ivwm_pkg::ST_WDIV: begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1) begin
                    state_next = ivwm_pkg::ST_WCLAMP;
                end
            end
            ivwm_pkg::ST_WCLAMP: begin
                if (|dvd_reg[ivwm_pkg::RECIP_W-1:ivwm_pkg::WEIGHT_W]) begin
                    w_next = ivwm_pkg::WEIGHT_MAX;
                end else begin
                    w_next = dvd_reg[ivwm_pkg::WEIGHT_W-1:0];
                end
                state_next = ivwm_pkg::ST_VWMUL;
            end
            ivwm_pkg::ST_VWMUL: begin
                vw_next    = vw_prod[63:0];
                state_next = ivwm_pkg::ST_ACC;
            end
            ivwm_pkg::ST_ACC: begin
                if (ws_sum[ivwm_pkg::WSUM_W]) begin
                    ws_next  = ivwm_pkg::WSUM_MAX;
                    ovf_next = 1'b1;
                end else begin
                    ws_next = ws_sum[ivwm_pkg::WSUM_W-1:0];
                end
                if (wvs_sum[64] != wvs_sum[63]) begin
                    wvs_next = wvs_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    ovf_next = 1'b1;
                end else begin
                    wvs_next = wvs_sum[63:0];
                end
                state_next = last_reg ? ivwm_pkg::ST_FIN : ivwm_pkg::ST_IDLE;
            end
            ivwm_pkg::ST_FIN: begin
                sat_next = ovf_reg;
                if (ws_reg == '0) begin
                    mean_next  = '0;
                    root_next  = '0;
                    nw_next    = 1'b1;
                    state_next = ivwm_pkg::ST_OUT;
                end else begin
                    nw_next    = 1'b0;
                    dsr_next   = ws_reg;
                    dvd_next   = wvs_mag;
                    rem_next   = '0;
                    cnt_next   = ivwm_pkg::MEAN_STEPS;
                    state_next = ivwm_pkg::ST_MDIV;
                end
            end
            ivwm_pkg::ST_MDIV: begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1) begin
                    // quotient magnitude is in div_dvd; clamp to Q16.16
                    if (!wvs_reg[63] && div_dvd > 64'h7FFF_FFFF) begin
                        mean_next = 32'h7FFF_FFFF;
                        sat_next  = 1'b1;
                    end else if (wvs_reg[63] && div_dvd > 64'h8000_0000) begin
                        mean_next = 32'h8000_0000;
                        sat_next  = 1'b1;
                    end else if (wvs_reg[63]) begin
                        mean_next = 32'(0) - div_dvd[31:0];
                    end else begin
                        mean_next = div_dvd[31:0];
                    end
                    dvd_next   = {1'b1, {(ivwm_pkg::DVD_W-1){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = ivwm_pkg::RECIP_STEPS;
                    state_next = ivwm_pkg::ST_EDIV;
                end
            end
            ivwm_pkg::ST_EDIV: begin
                dvd_next = div_dvd;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1) begin
                    x_next     = div_dvd[ivwm_pkg::RECIP_W-1:0];
                    root_next  = '0;
                    bit_next   = {1'b1, {(ivwm_pkg::RECIP_W-1){1'b0}}};
                    cnt_next   = ivwm_pkg::ROOT_STEPS;
                    state_next = ivwm_pkg::ST_ROOT;
                end
            end
            ivwm_pkg::ST_ROOT: begin
                if (root_take) begin
                    x_next    = x_reg - ivwm_pkg::RECIP_W'(root_trial);
                    root_next = (root_reg >> 1) + ivwm_pkg::ROOT_W'(bit_reg);
                end else begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 1) begin
                    state_next = ivwm_pkg::ST_OUT;
                end
            end
            ivwm_pkg::ST_OUT: begin
                if (out_free) begin
                    m_tdata_next  = {root_reg[31:0], mean_reg};
                    m_tuser_next  = {sat_reg, nw_reg};
                    m_tvalid_next = 1'b1;
                    ws_next       = '0;
                    wvs_next      = '0;
                    ovf_next      = 1'b0;
                    state_next    = ivwm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ivwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ivwm_pkg::ST_IDLE;
            ws_reg       <= '0;
            wvs_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ws_reg       <= ws_next;
            wvs_reg      <= wvs_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        err_reg     <= err_next;
        scale_reg   <= scale_next;
        last_reg    <= last_next;
        prod_reg    <= prod_next;
        w_reg       <= w_next;
        vw_reg      <= vw_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dsr_reg     <= dsr_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        mean_reg    <= mean_next;
        sat_reg     <= sat_next;
        nw_reg      <= nw_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

// ===== tb/ivwm_checker.sv =====
module ivwm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,    // value[31:0], error[63:32], error_scale[79:64]
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // mean[31:0], mean_error[63:32]
    input  logic [1:0]  m_tuser,    // no_weight[0], saturated[1]
    output int          fail_count,
    output int          pending_bins
);

    typedef struct packed {
        logic [31:0] mean;
        logic [31:0] mean_error;
        logic        no_weight;
        logic        saturated;
    } bin_result_t;

    // running sums of the open bin
    logic [ivwm_pkg::WSUM_W-1:0]  wsum   = '0;
    logic [ivwm_pkg::VWSUM_W-1:0] vwsum  = '0;    // two's complement
    logic                         ovf    = 1'b0;
    bin_result_t                  bin_results_q[$];
    int                           bins_checked = 0;

    initial begin
        fail_count   = 0;
        pending_bins = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: bin %0d %s got %h want %h", $time, bins_checked, field, got, want);
        fail_count++;
    endtask

    function automatic logic [ivwm_pkg::WEIGHT_W-1:0] inv_sq_weight(input logic [31:0] err,
                                                                    input logic [15:0] scale);
        logic [47:0] prod;
        logic [33:0] es;
        logic [63:0] q;
        prod = 48'(err) * 48'(scale);
        es   = prod[47:14];
        if (es == '0 || es > ivwm_pkg::ES_LIMIT)
            return '0;
        q = (64'd1 << 40) / (64'(es) * 64'(es));
        return (q > 64'(ivwm_pkg::WEIGHT_MAX)) ? ivwm_pkg::WEIGHT_MAX : q[31:0];
    endfunction

    // bitwise integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rest;
        root  = '0;
        probe = 64'd1 << 62;
        rest  = x;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != '0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    task automatic accumulate_measurement(input logic [31:0] value, input logic [31:0] err,
                                          input logic [15:0] scale, input logic last);
        logic [31:0] w;
        logic [63:0] vw;
        logic [64:0] total;
        logic [63:0] mag;
        logic [63:0] quot;
        logic [63:0] root;
        logic        neg;
        bin_result_t res;
        w  = inv_sq_weight(err, scale);
        vw = $signed({{32{value[31]}}, value}) * $signed({32'b0, w});

        if (48'(w) > ivwm_pkg::WSUM_MAX - wsum) begin
            wsum = ivwm_pkg::WSUM_MAX;
            ovf  = 1'b1;
        end else begin
            wsum = wsum + 48'(w);
        end

        // 65-bit sum: top two bits differ only on overflow
        total = {vwsum[63], vwsum} + {vw[63], vw};
        if (total[64] != total[63]) begin
            vwsum = total[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
            ovf   = 1'b1;
        end else begin
            vwsum = total[63:0];
        end

        if (!last)
            return;

        res.saturated = ovf;
        if (wsum == '0) begin
            res.mean       = '0;
            res.mean_error = '0;
            res.no_weight  = 1'b1;
        end else begin
            neg  = vwsum[63];
            mag  = neg ? (64'd0 - vwsum) : vwsum;
            quot = mag / 64'(wsum);
            if (!neg && quot > 64'h7FFF_FFFF) begin
                res.mean      = 32'h7FFF_FFFF;
                res.saturated = 1'b1;
            end else if (neg && quot > 64'h8000_0000) begin
                res.mean      = 32'h8000_0000;
                res.saturated = 1'b1;
            end else begin
                res.mean = neg ? (32'd0 - quot[31:0]) : quot[31:0];
            end
            root           = floor_sqrt((64'd1 << 40) / 64'(wsum));
            res.mean_error = root[31:0];
            res.no_weight  = 1'b0;
        end
        bin_results_q.insert(bin_results_q.size(), res);

        wsum  = '0;
        vwsum = '0;
        ovf   = 1'b0;
    endtask

    always @(posedge aclk) begin : watch
        bin_result_t want;
        if (!aresetn) begin
            wsum  = '0;
            vwsum = '0;
            ovf   = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (bin_results_q.size() == 0) begin
                    report_mismatch("result with no bin closed, mean", m_tdata[31:0], '0);
                end else begin
                    want = bin_results_q.pop_front();
                    if (m_tdata[31:0] !== want.mean)
                        report_mismatch("mean", m_tdata[31:0], want.mean);
                    if (m_tdata[63:32] !== want.mean_error)
                        report_mismatch("mean_error", m_tdata[63:32], want.mean_error);
                    if (m_tuser[0] !== want.no_weight)
                        report_mismatch("no_weight", 32'(m_tuser[0]), 32'(want.no_weight));
                    if (m_tuser[1] !== want.saturated)
                        report_mismatch("saturated", 32'(m_tuser[1]), 32'(want.saturated));
                end
                bins_checked++;
            end
            if (s_tvalid && s_tready)
                accumulate_measurement(s_tdata[31:0], s_tdata[63:32], s_tdata[79:64], s_tlast);
        end
        pending_bins = bin_results_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    localparam int N_ITEMS      = 1850;
    localparam int HOLD_AT      = 200;        // items accepted before the long hold-off
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 300;        // longer than one last-item pass
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;    // value[31:0], error[63:32], error_scale[79:64]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // mean[31:0], mean_error[63:32]
    logic [1:0]  m_tuser;          // no_weight[0], saturated[1]

    int fail_count;
    int pending_bins;
    int items_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    always #4 aclk = ~aclk;

    inverse_variance_weighted_mean DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ivwm_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending_bins (pending_bins)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one measurement and hold it until accepted. Bursts of random length;
    // the gap before a new burst drops tvalid, a zero gap keeps it high.
    task automatic push_item(input logic [31:0] value, input logic [31:0] err,
                             input logic [15:0] scale, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {scale, err, value};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // One bin of random measurements. Most errors land where the weight is
    // nonzero; zero, tiny (clamped weight) and huge (zero weight) errors mixed in.
    task automatic random_bin();
        int          len;
        int          pick;
        logic [31:0] value;
        logic [31:0] err;
        logic [15:0] scale;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0)
                value = 32'h7FFF_FFFF;
            else if (pick == 1)
                value = 32'h8000_0000;
            else if (pick == 2) begin
                value = $urandom_range(0, 32'h000F_FFFF);
                if ($urandom_range(0, 1) == 1)
                    value = 32'd0 - value;
            end else
                value = $urandom();

            pick = $urandom_range(0, 15);
            if (pick == 0)
                err = '0;
            else if (pick <= 2)
                err = $urandom_range(1, 255);
            else if (pick <= 10)
                err = $urandom_range(32'h0000_0400, 32'h0040_0000);
            else if (pick == 11)
                err = 32'hFFFF_FFFF;
            else
                err = $urandom();

            pick = $urandom_range(0, 15);
            if (pick == 0)
                scale = '0;
            else if (pick <= 7)
                scale = 16'h4000;    // 1.0 in Q2.14
            else if (pick == 8)
                scale = 16'hFFFF;
            else if (pick == 9)
                scale = 16'h0001;
            else
                scale = $urandom_range(1, 16'hFFFF);

            push_item(value, err, scale, i == len - 1);
        end
    endtask

    // sender: reset, directed bins, random bins, verdict
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // single-item bins at the value extremes, weight 256
        push_item(32'h7FFF_FFFF, 32'h0001_0000, 16'h4000, 1'b1);
        push_item(32'h8000_0000, 32'h0001_0000, 16'h4000, 1'b1);
        // zero error, then zero scale: empty weight sum
        push_item(32'h0001_0000, 32'h0000_0000, 16'h4000, 1'b1);
        push_item(32'h0001_0000, 32'h0001_0000, 16'h0000, 1'b1);
        // tiny scaled error: weight clamps to all ones, no saturation flag
        push_item(32'h0000_3039, 32'h0000_0001, 16'h4000, 1'b1);
        // scaled error above 2^20: weight zero
        push_item(32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        // scaled error exactly 2^20: weight one
        push_item(32'hFFFE_0000, 32'h0010_0000, 16'h4000, 1'b1);
        // full-weight extremes overflow the value sum, both signs
        for (int i = 0; i < 3; i++)
            push_item(32'h7FFF_FFFF, 32'h0000_0001, 16'h4000, i == 2);
        for (int i = 0; i < 3; i++)
            push_item(32'h8000_0000, 32'h0000_0001, 16'h4000, i == 2);
        // mixed weights in one bin
        push_item(32'h0001_0000, 32'h0001_0000, 16'h4000, 1'b0);
        push_item(32'hFFFD_0000, 32'h0002_0000, 16'h4000, 1'b0);
        push_item(32'h0000_8000, 32'h0000_8000, 16'h8000, 1'b1);
        // zero-weight item followed by a weighted one
        push_item(32'h7FFF_0000, 32'h0000_0000, 16'hFFFF, 1'b0);
        push_item(32'hFFFF_FFFF, 32'h0000_4000, 16'h4000, 1'b1);
        // largest error with the smallest scale still gives a weight
        push_item(32'h0000_0000, 32'hFFFF_FFFF, 16'h0001, 1'b1);
        // maximum scale
        push_item(32'h5555_AAAA, 32'h0000_1000, 16'hFFFF, 1'b1);

        while (items_sent < N_ITEMS)
            random_bin();
        s_tvalid <= 1'b0;

        // checker updates its queue on the same edge; look after the next edge
        @(posedge aclk);
        wait (pending_bins == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver: stall pattern in random modes, plus one long hold-off that
    // lets the block back up and drop s_tready while items keep coming
    initial begin : rx_side
        int mode;
        int mode_left;
        int hold_left;
        bit held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held && items_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= mode_left[2];
                endcase
            end
        end
    end

endmodule

// ===== filelist.f =====
design/ivwm_pkg.sv
design/inverse_variance_weighted_mean.sv
tb/ivwm_checker.sv
tb/tb_top.sv
